[sv/rate_pkg.sv]
`default_nettype none
package rate_pkg;

  // Accumulator and field widths
  localparam int HT_W   = 21;
  localparam int MHT_W  = 23;
  localparam int DHT_W  = 16;
  localparam int ET_W   = 16;
  localparam int PHI_W  = 12;
  localparam int MAG_W  = 17;
  localparam int ALPHA_W = 16;

  // Root unit operand width (covers mx^2 + my^2) and result width
  localparam int SQ_W    = 46;
  localparam int ROOT_W  = 23;

  localparam int MAX_JETS_DEF = 32;

  localparam logic [HT_W-1:0]    HT_MAX    = '1;
  localparam logic [30:0]        HALF_PI_Q30 = 31'd1686629713;
  localparam logic [31:0]        ONE_Q30   = 32'h4000_0000;
  localparam logic [MAG_W-1:0]   MAG_MAX   = 17'd65536;
  localparam logic [ALPHA_W-1:0] ALPHA_SAT = '1;
  localparam logic [2:0]         POLY_LAST = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ANG,
    ST_SQ_ANG,
    ST_POLY_MUL,
    ST_POLY_RCP,
    ST_POLY_FIX,
    ST_TRIG_END,
    ST_PROJ_X,
    ST_PROJ_Y,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_HT,
    ST_ROOT_M,
    ST_ROOT_D,
    ST_DIV_SET,
    ST_DIV,
    ST_DONE
  } rate_state_t;

  // Taylor divisors, highest order first
  function automatic logic [6:0] poly_div(input logic [2:0] idx);
    logic [6:0] d;
    unique case (idx)
      3'd0:    d = 7'd110;
      3'd1:    d = 7'd72;
      3'd2:    d = 7'd42;
      3'd3:    d = 7'd20;
      default: d = 7'd6;
    endcase
    return d;
  endfunction

  // floor(2^32 / divisor), used for quotient estimates
  function automatic logic [31:0] poly_rcp(input logic [2:0] idx);
    logic [31:0] m;
    unique case (idx)
      3'd0:    m = 32'd39045157;
      3'd1:    m = 32'd59652323;
      3'd2:    m = 32'd102261126;
      3'd3:    m = 32'd214748364;
      default: m = 32'd715827882;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

[sv/rate_isqrt.sv]
`default_nettype none
module rate_isqrt
  import rate_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [SQ_W-1:0] operand,
  output logic                 done,
  output logic [ROOT_W-1:0]    root
);

  logic [SQ_W-1:0] rem;
  logic [SQ_W-1:0] acc;
  logic [SQ_W-1:0] bitv;
  logic            busy;
  logic [SQ_W-1:0] trial;

  assign trial = acc + bitv;
  assign root  = acc[ROOT_W-1:0];

  // Resolve one root bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= operand;
        acc  <= '0;
        bitv <= SQ_W'(1) << (SQ_W - 2);
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          acc <= (acc >> 1) + bitv;
        end else begin
          acc <= acc >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv[0]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

[sv/running_alpha_t_estimator_core.sv]
`default_nettype none
// Running alphaT estimator. Each request is one jet; tuser carries the
// first-jet flag that clears the event sums. One result follows every jet:
// HT, MHT, dHT, alphaT (Q2.14) and an invalid flag. The block works on one
// jet at a time: a single 32x32 multiplier evaluates cos and sin by Taylor
// polynomials (18 products each), projects Pt and squares the sums, then a
// bit-serial root unit runs twice and a 16-step divider forms alphaT. A
// non-positive root argument skips the second root and the divider; a
// saturated alphaT skips the divider. Jets past MAX_JETS in an event skip
// the trig and projection work and return the sums.
// Input is taken only while no jet is in work; a finished result waits in
// the output register without blocking the next request.
module running_alpha_t_estimator_core
  import rate_pkg::*;
#(
  parameter int MAX_JETS = MAX_JETS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // jet_et[15:0], jet_pt[31:16], jet_phi[43:32], zero pad
  input  wire logic [47:0] s_axis_tdata,
  // first_jet[0]
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // sum_ht[20:0], missing_ht[41:21], delta_ht[57:42], alpha_t[73:58], zero pad
  output logic [79:0]      m_axis_tdata,
  // alpha_invalid[0]
  output logic             m_axis_tuser
);

  localparam int CNT_W = $clog2(MAX_JETS + 1);

  rate_state_t state, state_next;

  // Event sums
  logic [HT_W-1:0]         ht;
  logic [DHT_W-1:0]        dht;
  logic signed [MHT_W-1:0] mx, my;
  logic [CNT_W-1:0]        cnt;

  // Jet under work
  logic [ET_W-1:0]  pt_r;
  logic [PHI_W-1:0] phi_r;
  logic             trig_sel;
  logic [MAG_W-1:0] cmag, smag;
  logic             cneg, sneg;

  // Polynomial registers
  logic [30:0] xa;
  logic [31:0] x2;
  logic [30:0] tp;
  logic [31:0] pv;
  logic [31:0] q0;
  logic [2:0]  pidx;

  // Magnitude and ratio registers
  logic [SQ_W-1:0]    m2;
  logic [SQ_W-1:0]    dsq;
  logic               invalid;
  logic [HT_W-1:0]    mht;
  logic [ROOT_W-1:0]  sden;
  logic [ROOT_W-1:0]  drem;
  logic [15:0]        dlo;
  logic [ALPHA_W-1:0] quo;
  logic [3:0]         dcnt;
  logic [ALPHA_W-1:0] alpha;

  // Shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  assign prod = 64'(mul_a) * 64'(mul_b);

  // Root unit
  logic              sq_start;
  logic [SQ_W-1:0]   sq_op;
  logic              sq_done;
  logic [ROOT_W-1:0] sq_root;

  rate_isqrt u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (sq_start),
    .operand (sq_op),
    .done    (sq_done),
    .root    (sq_root)
  );

  // Input fields
  logic             in_first;
  logic [ET_W-1:0]  in_et;
  logic             accept;
  assign in_first = s_axis_tuser;
  assign in_et    = s_axis_tdata[15:0];
  assign accept   = s_axis_tvalid && s_axis_tready;

  // Accumulator updates for a new jet
  logic [CNT_W-1:0] cnt_eff;
  logic [HT_W-1:0]  ht_eff;
  logic [DHT_W-1:0] dht_eff;
  logic [HT_W:0]    ht_sum;
  logic [DHT_W:0]   dht_a;
  logic [DHT_W-1:0] dht_b;
  logic             take_jet;

  assign cnt_eff  = in_first ? '0 : cnt;
  assign ht_eff   = in_first ? '0 : ht;
  assign dht_eff  = in_first ? '0 : dht;
  assign take_jet = cnt_eff < CNT_W'(MAX_JETS);
  assign ht_sum   = {1'b0, ht_eff} + (HT_W+1)'(in_et);
  assign dht_a    = {1'b0, dht_eff} + {1'b0, in_et};
  assign dht_b    = (dht_eff >= in_et) ? dht_eff - in_et : in_et - dht_eff;

  // Quadrant folding of the current angle
  logic [PHI_W-1:0] p_ang;
  logic [10:0]      q_arg;
  logic             q_neg;
  assign p_ang = trig_sel ? phi_r : phi_r + PHI_W'(1024);
  assign q_arg = p_ang[10] ? 11'd1024 - {1'b0, p_ang[9:0]} : {1'b0, p_ang[9:0]};
  assign q_neg = p_ang[11];

  // Polynomial step helpers
  logic [32:0] fix_rem;
  logic [31:0] q_fix;
  logic [31:0] t_new;
  assign fix_rem = {1'b0, pv} - prod[32:0];
  assign q_fix   = (fix_rem >= 33'(poly_div(pidx))) ? q0 + 32'd1 : q0;
  assign t_new   = ONE_Q30 - q_fix;

  logic [18:0]      mag_rnd;
  logic [MAG_W-1:0] mag_cap;
  assign mag_rnd = 19'((33'(prod[61:30]) + 33'd8192) >> 14);
  assign mag_cap = (mag_rnd > 19'(MAG_MAX)) ? MAG_MAX : mag_rnd[MAG_W-1:0];

  // Projection onto one axis, subtracted with saturation
  logic [MAG_W-1:0]      part;
  logic signed [MHT_W+1:0] proj_acc;
  logic signed [MHT_W+1:0] proj_new;
  logic                  proj_neg;
  logic signed [MHT_W-1:0] proj_sat;
  localparam logic signed [MHT_W+1:0] MHT_HI = (MHT_W+2)'((1 << (MHT_W - 1)) - 1);
  localparam logic signed [MHT_W+1:0] MHT_LO = -(MHT_W+2)'(1 << (MHT_W - 1));

  assign part     = 17'((prod[33:0] + 34'd32768) >> 16);
  assign proj_acc = (state == ST_PROJ_X) ? (MHT_W+2)'(mx) : (MHT_W+2)'(my);
  assign proj_neg = (state == ST_PROJ_X) ? cneg : sneg;
  assign proj_new = proj_neg ? proj_acc + (MHT_W+2)'(part) : proj_acc - (MHT_W+2)'(part);
  assign proj_sat = (proj_new > MHT_HI) ? MHT_HI[MHT_W-1:0] :
                    (proj_new < MHT_LO) ? MHT_LO[MHT_W-1:0] : proj_new[MHT_W-1:0];

  logic [MHT_W-1:0] mx_abs, my_abs;
  assign mx_abs = mx[MHT_W-1] ? MHT_W'(-mx) : MHT_W'(mx);
  assign my_abs = my[MHT_W-1] ? MHT_W'(-my) : MHT_W'(my);

  // HT squared against the MHT square
  logic [SQ_W-1:0] ht2;
  assign ht2 = SQ_W'(prod[2*HT_W-1:0]);

  // Division helpers
  logic [HT_W-1:0]   num;
  logic [ROOT_W:0]   dtrial;
  assign num    = (ht > HT_W'(dht)) ? ht - HT_W'(dht) : '0;
  assign dtrial = {drem, dlo[15]};

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (accept) state_next = take_jet ? ST_ANG : ST_SQ_X;
      ST_ANG:      state_next = ST_SQ_ANG;
      ST_SQ_ANG:   state_next = ST_POLY_MUL;
      ST_POLY_MUL: state_next = ST_POLY_RCP;
      ST_POLY_RCP: state_next = ST_POLY_FIX;
      ST_POLY_FIX: state_next = (pidx == POLY_LAST) ? ST_TRIG_END : ST_POLY_MUL;
      ST_TRIG_END: state_next = trig_sel ? ST_PROJ_X : ST_ANG;
      ST_PROJ_X:   state_next = ST_PROJ_Y;
      ST_PROJ_Y:   state_next = ST_SQ_X;
      ST_SQ_X:     state_next = ST_SQ_Y;
      ST_SQ_Y:     state_next = ST_SQ_HT;
      ST_SQ_HT:    state_next = ST_ROOT_M;
      ST_ROOT_M:   if (sq_done) state_next = invalid ? ST_DONE : ST_ROOT_D;
      ST_ROOT_D:   if (sq_done) state_next = ST_DIV_SET;
      ST_DIV_SET:  state_next = (ROOT_W'(num[HT_W-1:3]) >= sden) ? ST_DONE : ST_DIV;
      ST_DIV:      if (dcnt == 4'd0) state_next = ST_DONE;
      ST_DONE:     if (!m_axis_tvalid || m_axis_tready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Unit controls per state
  always_comb begin
    mul_a         = '0;
    mul_b         = '0;
    sq_start      = 1'b0;
    sq_op         = m2;
    s_axis_tready = (state == ST_IDLE);
    unique case (state)
      ST_ANG: begin
        mul_a = 32'(q_arg);
        mul_b = 32'(HALF_PI_Q30);
      end
      ST_SQ_ANG: begin
        mul_a = 32'(xa);
        mul_b = 32'(xa);
      end
      ST_POLY_MUL: begin
        mul_a = x2;
        mul_b = 32'(tp);
      end
      ST_POLY_RCP: begin
        mul_a = pv;
        mul_b = poly_rcp(pidx);
      end
      ST_POLY_FIX: begin
        mul_a = q0;
        mul_b = 32'(poly_div(pidx));
      end
      ST_TRIG_END: begin
        mul_a = 32'(xa);
        mul_b = 32'(tp);
      end
      ST_PROJ_X: begin
        mul_a = 32'(pt_r);
        mul_b = 32'(cmag);
      end
      ST_PROJ_Y: begin
        mul_a = 32'(pt_r);
        mul_b = 32'(smag);
      end
      ST_SQ_X: begin
        mul_a = 32'(mx_abs);
        mul_b = 32'(mx_abs);
      end
      ST_SQ_Y: begin
        mul_a = 32'(my_abs);
        mul_b = 32'(my_abs);
      end
      ST_SQ_HT: begin
        mul_a    = 32'(ht);
        mul_b    = 32'(ht);
        sq_start = 1'b1;
        sq_op    = m2;
      end
      ST_ROOT_M: begin
        sq_start = sq_done && !invalid;
        sq_op    = dsq;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      ht            <= '0;
      dht           <= '0;
      mx            <= '0;
      my            <= '0;
      cnt           <= '0;
    end else begin
      state <= state_next;

      // Load a new result, or drop a taken one
      if (state == ST_DONE && (!m_axis_tvalid || m_axis_tready)) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;

      // Take a jet into the event sums
      if (accept) begin
        if (in_first) begin
          mx <= '0;
          my <= '0;
        end
        if (take_jet) begin
          cnt <= cnt_eff + CNT_W'(1);
          ht  <= ht_sum[HT_W] ? HT_MAX : ht_sum[HT_W-1:0];
          dht <= (dht_a < {1'b0, dht_b}) ? dht_a[DHT_W-1:0] : dht_b;
        end else begin
          cnt <= cnt_eff;
          ht  <= ht_eff;
          dht <= dht_eff;
        end
      end
      if (state == ST_PROJ_X) mx <= proj_sat;
      if (state == ST_PROJ_Y) my <= proj_sat;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        pt_r     <= s_axis_tdata[31:16];
        phi_r    <= s_axis_tdata[43:32];
        trig_sel <= 1'b0;
      end
      ST_ANG: begin
        xa <= prod[40:10] + 31'(prod[9]);
      end
      ST_SQ_ANG: begin
        x2   <= 32'((prod + 64'h2000_0000) >> 30);
        tp   <= ONE_Q30[30:0];
        pidx <= '0;
      end
      ST_POLY_MUL: pv <= prod[61:30];
      ST_POLY_RCP: q0 <= prod[63:32];
      ST_POLY_FIX: begin
        tp   <= t_new[30:0];
        pidx <= pidx + 3'd1;
      end
      ST_TRIG_END: begin
        if (trig_sel) begin
          smag <= mag_cap;
          sneg <= q_neg;
        end else begin
          cmag <= mag_cap;
          cneg <= q_neg;
        end
        trig_sel <= 1'b1;
      end
      ST_SQ_X: m2 <= prod[SQ_W-1:0];
      ST_SQ_Y: m2 <= m2 + prod[SQ_W-1:0];
      ST_SQ_HT: begin
        invalid <= !(ht2 > m2);
        dsq     <= ht2 - m2;
      end
      ST_ROOT_M: begin
        if (sq_done) begin
          mht   <= (sq_root > ROOT_W'(HT_MAX)) ? HT_MAX : sq_root[HT_W-1:0];
          alpha <= ALPHA_SAT;
        end
      end
      ST_ROOT_D: if (sq_done) sden <= sq_root;
      ST_DIV_SET: begin
        drem  <= ROOT_W'(num[HT_W-1:3]);
        dlo   <= {num[2:0], 13'd0};
        quo   <= '0;
        dcnt  <= 4'd15;
        alpha <= ALPHA_SAT;
      end
      ST_DIV: begin
        if (dtrial >= {1'b0, sden}) begin
          drem <= ROOT_W'(dtrial - {1'b0, sden});
          quo  <= {quo[ALPHA_W-2:0], 1'b1};
        end else begin
          drem <= dtrial[ROOT_W-1:0];
          quo  <= {quo[ALPHA_W-2:0], 1'b0};
        end
        dlo  <= {dlo[14:0], 1'b0};
        dcnt <= dcnt - 4'd1;
        if (dcnt == 4'd0) begin
          alpha <= (dtrial >= {1'b0, sden}) ? {quo[ALPHA_W-2:0], 1'b1}
                                            : {quo[ALPHA_W-2:0], 1'b0};
        end
      end
      ST_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          m_axis_tdata <= {6'd0, alpha, dht, mht, ht};
          m_axis_tuser <= invalid;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire
